/* rtl/dwpw_pkg.sv */
// ----------------------------------------------------------------------------
// Display window pixel writer package
// Shared request types, command codes and the control-to-output bundle.
// ----------------------------------------------------------------------------
package dwpw_pkg;

  // Bus kind bit: command or data byte.
  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_DATA    = 1'b1;

  // Display command codes that the block acts on.
  localparam logic [7:0] CMD_NONE         = 8'h00;
  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned AddrWidth  = 18;
  localparam int unsigned PixelWidth = 16;

  // One input request: a byte from the parallel bus.
  typedef struct packed {
    logic       kind;
    logic [7:0] bus_byte;
  } in_item_t;

  // One result request: a frame-memory write.
  typedef struct packed {
    logic [AddrWidth-1:0]  mem_address;
    logic [PixelWidth-1:0] pixel_value;
  } out_item_t;

  // Pixel write handed from the command decoder to the output stage.
  typedef struct packed {
    logic                  valid;
    logic [CoordWidth-1:0] col;
    logic [CoordWidth-1:0] page;
    logic [PixelWidth-1:0] pixel;
  } pix_req_t;

endpackage

/* rtl/dwpw_ctrl.sv */
// ----------------------------------------------------------------------------
// Display window pixel writer command decoder
// Tracks the active command, the column and page windows and the cursor, and
// forms pixel writes from pairs of data bytes.
// ----------------------------------------------------------------------------
module dwpw_ctrl #(
  parameter int unsigned PANEL_WIDTH  = 480,
  parameter int unsigned PANEL_HEIGHT = 320
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  dwpw_pkg::in_item_t item_i,
  output dwpw_pkg::pix_req_t pix_o
);

  localparam int unsigned CW = dwpw_pkg::CoordWidth;

  // Parameter byte positions inside a window command.
  localparam logic [2:0] PARAM_FIRST_HI = 3'd0;
  localparam logic [2:0] PARAM_FIRST_LO = 3'd1;
  localparam logic [2:0] PARAM_LAST_HI  = 3'd2;
  localparam logic [2:0] PARAM_LAST_LO  = 3'd3;
  localparam logic [2:0] PARAM_DONE     = 3'd4;

  logic [7:0]    cmd_q, cmd_d;
  logic [2:0]    idx_q, idx_d;
  logic [CW-1:0] col_first_q, col_first_d;
  logic [CW-1:0] col_last_q, col_last_d;
  logic [CW-1:0] page_first_q, page_first_d;
  logic [CW-1:0] page_last_q, page_last_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [CW-1:0] cur_page_q, cur_page_d;
  logic [7:0]    held_q, held_d;
  logic          pend_q, pend_d;

  logic          win_sel_col;
  logic [CW-1:0] win_first, win_last;
  logic [CW-1:0] win_first_new, win_last_new;
  logic          on_panel;
  logic          pixel_done;

  // Window register being loaded by the current command.
  assign win_first = win_sel_col ? col_first_q : page_first_q;
  assign win_last  = win_sel_col ? col_last_q  : page_last_q;

  // Byte merge into the window half that the parameter position selects.
  always_comb begin
    win_first_new = win_first;
    win_last_new  = win_last;
    unique case (idx_q)
      PARAM_FIRST_HI: win_first_new = {item_i.bus_byte, win_first[7:0]};
      PARAM_FIRST_LO: win_first_new = {win_first[CW-1:8], item_i.bus_byte};
      PARAM_LAST_HI:  win_last_new  = {item_i.bus_byte, win_last[7:0]};
      PARAM_LAST_LO:  win_last_new  = {win_last[CW-1:8], item_i.bus_byte};
      default: begin
        win_first_new = win_first;
        win_last_new  = win_last;
      end
    endcase
  end

  assign on_panel = (cur_col_q < CW'(PANEL_WIDTH)) && (cur_page_q < CW'(PANEL_HEIGHT));

  // Next-state logic for one accepted byte.
  always_comb begin
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    col_first_d  = col_first_q;
    col_last_d   = col_last_q;
    page_first_d = page_first_q;
    page_last_d  = page_last_q;
    cur_col_d    = cur_col_q;
    cur_page_d   = cur_page_q;
    held_d       = held_q;
    pend_d       = pend_q;
    win_sel_col  = 1'b0;
    pixel_done   = 1'b0;

    if (accept_i) begin
      if (item_i.kind == dwpw_pkg::KIND_COMMAND) begin
        cmd_d  = item_i.bus_byte;
        idx_d  = PARAM_FIRST_HI;
        pend_d = 1'b0;
        if (item_i.bus_byte == dwpw_pkg::CMD_MEMORY_WRITE) begin
          cur_col_d  = col_first_q;
          cur_page_d = page_first_q;
        end
      end else begin
        unique case (cmd_q)
          dwpw_pkg::CMD_COLUMN_SET: begin
            win_sel_col = 1'b1;
            col_first_d = win_first_new;
            col_last_d  = win_last_new;
            if (idx_q != PARAM_DONE) begin
              idx_d = idx_q + 3'd1;
            end
          end
          dwpw_pkg::CMD_PAGE_SET: begin
            page_first_d = win_first_new;
            page_last_d  = win_last_new;
            if (idx_q != PARAM_DONE) begin
              idx_d = idx_q + 3'd1;
            end
          end
          dwpw_pkg::CMD_MEMORY_WRITE: begin
            if (!pend_q) begin
              held_d = item_i.bus_byte;
              pend_d = 1'b1;
            end else begin
              pend_d     = 1'b0;
              pixel_done = 1'b1;
              // Step the cursor row by row and wrap at the window end.
              if (cur_col_q >= col_last_q) begin
                cur_col_d = col_first_q;
                if (cur_page_q >= page_last_q) begin
                  cur_page_d = page_first_q;
                end else begin
                  cur_page_d = cur_page_q + CW'(1);
                end
              end else begin
                cur_col_d = cur_col_q + CW'(1);
              end
            end
          end
          default: begin
            cmd_d = cmd_q;
          end
        endcase
      end
    end
  end

  // Pixel write toward the output stage, taken from the cursor before it moves.
  always_comb begin
    pix_o.valid = pixel_done && on_panel;
    pix_o.col   = cur_col_q;
    pix_o.page  = cur_page_q;
    pix_o.pixel = {held_q, item_i.bus_byte};
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= dwpw_pkg::CMD_NONE;
      idx_q        <= PARAM_FIRST_HI;
      col_first_q  <= '0;
      col_last_q   <= CW'(PANEL_WIDTH - 1);
      page_first_q <= '0;
      page_last_q  <= CW'(PANEL_HEIGHT - 1);
      cur_col_q    <= '0;
      cur_page_q   <= '0;
      held_q       <= '0;
      pend_q       <= 1'b0;
    end else begin
      cmd_q        <= cmd_d;
      idx_q        <= idx_d;
      col_first_q  <= col_first_d;
      col_last_q   <= col_last_d;
      page_first_q <= page_first_d;
      page_last_q  <= page_last_d;
      cur_col_q    <= cur_col_d;
      cur_page_q   <= cur_page_d;
      held_q       <= held_d;
      pend_q       <= pend_d;
    end
  end

endmodule

/* rtl/dwpw_out.sv */
// ----------------------------------------------------------------------------
// Display window pixel writer output stage
// Computes the frame-memory address and holds the result request until the
// receiver takes it.
// ----------------------------------------------------------------------------
module dwpw_out #(
  parameter int unsigned PANEL_WIDTH = 480
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dwpw_pkg::pix_req_t  pix_i,
  output logic                slot_free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dwpw_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = dwpw_pkg::AddrWidth;

  logic                valid_q, valid_d;
  dwpw_pkg::out_item_t item_q;
  logic [AW-1:0]       addr;
  logic                load;

  // The slot is free when empty or being emptied in this cycle.
  assign slot_free_o = !valid_q || out_ready_i;
  assign load        = slot_free_o && pix_i.valid;

  // Row-major address, page times panel width plus column, kept to 18 bits.
  assign addr = AW'(32'(pix_i.page) * 32'(PANEL_WIDTH) + 32'(pix_i.col));

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.mem_address <= addr;
      item_q.pixel_value <= pix_i.pixel;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

/* rtl/display_window_pixel_writer_unit.sv */
// ----------------------------------------------------------------------------
// Display window pixel writer
// Turns a display bus byte stream into frame-memory pixel writes.
// ----------------------------------------------------------------------------
// The input channel carries one bus byte per request, flagged as command or
// data. Commands 0x2A and 0x2B load the column and page windows from four data
// bytes each; command 0x2C moves the cursor to the window start, after which
// each pair of data bytes (high byte first) becomes one pixel write.
// The output channel carries one frame-memory write per request: the address
// page * PANEL_WIDTH + column and the 16-bit pixel. Pixels off the panel are
// dropped, and the cursor still advances.
// Throughput is one byte per cycle while the output register is free. A pixel
// write appears on the output in the cycle after its low byte is accepted; the
// address multiply sits between the window state and the output register.
// When the receiver stalls, the finished write stays in the output register
// and the input takes no byte of any kind until that write is taken; input
// ready follows the receiver's ready in the same cycle while it is held.
// Reset returns the windows to the full panel, the cursor to the origin and
// clears the active command; the output is empty after reset.
// ----------------------------------------------------------------------------
module display_window_pixel_writer_unit #(
  parameter int unsigned PANEL_WIDTH  = 480,
  parameter int unsigned PANEL_HEIGHT = 320
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dwpw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dwpw_pkg::out_item_t out_item_o
);

  dwpw_pkg::pix_req_t pix;
  logic               slot_free;
  logic               accept;

  // A byte is taken whenever the output register can take its result.
  assign in_ready_o = slot_free;
  assign accept     = in_valid_i && slot_free;

  dwpw_ctrl #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .pix_o   (pix)
  );

  dwpw_out #(
    .PANEL_WIDTH(PANEL_WIDTH)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .slot_free_o(slot_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

/* rtl/dwpw_checker.sv */
// ----------------------------------------------------------------------------
// Display window pixel writer checker
// Port-level assertions on the pixel writer, attached by bind.
// ----------------------------------------------------------------------------
module dwpw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input dwpw_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dwpw_pkg::out_item_t out_item_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  // The input is never blocked while the output register is empty.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output");

  // A command byte never produces a pixel write.
  a_cmd_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.kind == dwpw_pkg::KIND_COMMAND |=> !out_valid_o)
    else $error("command byte produced a result");

  // The first data byte after a command is never a complete pixel.
  a_first_data_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.kind == dwpw_pkg::KIND_COMMAND)
      ##1 (in_acc && in_item_i.kind == dwpw_pkg::KIND_DATA) |=> !out_valid_o)
    else $error("single data byte after a command produced a result");

endmodule

bind display_window_pixel_writer_unit dwpw_checker u_dwpw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
